// ===== rtl/core/zam_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zam_pkg
// Shared types, operation codes and default sizes of the bytecode execute unit.
// ---------------------------------------------------------------------------
package zam_pkg;

	localparam int STACK_DEPTH_DEF  = 256;
	localparam int GLOBAL_SLOTS_DEF = 64;
	localparam int WORD_BITS_DEF    = 32;
	localparam int PC_BITS_DEF      = 16;

	localparam int ACTION_BITS  = 6;
	localparam int OPERAND_BITS = 32;
	localparam int CFG_BITS     = 16;
	localparam int FAULT_BITS   = 3;
	localparam int LEN_BITS     = 3;
	localparam int GUARD_SLOTS  = 8;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [CFG_BITS-1:0] YIELD_RESET = 16'd1000;

	// dense operation codes
	localparam logic [ACTION_BITS-1:0] OP_CONST0      = 6'd0;
	localparam logic [ACTION_BITS-1:0] OP_CONST3      = 6'd3;
	localparam logic [ACTION_BITS-1:0] OP_CONSTINT    = 6'd4;
	localparam logic [ACTION_BITS-1:0] OP_ACC0        = 6'd5;
	localparam logic [ACTION_BITS-1:0] OP_ACC7        = 6'd12;
	localparam logic [ACTION_BITS-1:0] OP_ACC         = 6'd13;
	localparam logic [ACTION_BITS-1:0] OP_PUSH        = 6'd14;
	localparam logic [ACTION_BITS-1:0] OP_PUSHACC0    = 6'd15;
	localparam logic [ACTION_BITS-1:0] OP_PUSHACC1    = 6'd16;
	localparam logic [ACTION_BITS-1:0] OP_PUSHACC3    = 6'd18;
	localparam logic [ACTION_BITS-1:0] OP_PUSHACC     = 6'd19;
	localparam logic [ACTION_BITS-1:0] OP_POP         = 6'd20;
	localparam logic [ACTION_BITS-1:0] OP_ASSIGN      = 6'd21;
	localparam logic [ACTION_BITS-1:0] OP_ADD         = 6'd22;
	localparam logic [ACTION_BITS-1:0] OP_SUB         = 6'd23;
	localparam logic [ACTION_BITS-1:0] OP_MUL         = 6'd24;
	localparam logic [ACTION_BITS-1:0] OP_DIV         = 6'd25;
	localparam logic [ACTION_BITS-1:0] OP_MOD         = 6'd26;
	localparam logic [ACTION_BITS-1:0] OP_NEG         = 6'd27;
	localparam logic [ACTION_BITS-1:0] OP_OFFSETINT   = 6'd28;
	localparam logic [ACTION_BITS-1:0] OP_AND         = 6'd29;
	localparam logic [ACTION_BITS-1:0] OP_OR          = 6'd30;
	localparam logic [ACTION_BITS-1:0] OP_XOR         = 6'd31;
	localparam logic [ACTION_BITS-1:0] OP_LSL         = 6'd32;
	localparam logic [ACTION_BITS-1:0] OP_LSR         = 6'd33;
	localparam logic [ACTION_BITS-1:0] OP_ASR         = 6'd34;
	localparam logic [ACTION_BITS-1:0] OP_EQ          = 6'd35;
	localparam logic [ACTION_BITS-1:0] OP_NEQ         = 6'd36;
	localparam logic [ACTION_BITS-1:0] OP_LT          = 6'd37;
	localparam logic [ACTION_BITS-1:0] OP_LE          = 6'd38;
	localparam logic [ACTION_BITS-1:0] OP_GT          = 6'd39;
	localparam logic [ACTION_BITS-1:0] OP_GE          = 6'd40;
	localparam logic [ACTION_BITS-1:0] OP_BRANCH      = 6'd41;
	localparam logic [ACTION_BITS-1:0] OP_BRANCHIF    = 6'd42;
	localparam logic [ACTION_BITS-1:0] OP_BRANCHIFNOT = 6'd43;
	localparam logic [ACTION_BITS-1:0] OP_STOP        = 6'd44;
	localparam logic [ACTION_BITS-1:0] OP_GETGLOBAL   = 6'd45;
	localparam logic [ACTION_BITS-1:0] OP_SETGLOBAL   = 6'd46;
	localparam logic [ACTION_BITS-1:0] OP_ATOM0       = 6'd47;

	typedef enum logic [FAULT_BITS-1:0] {
		FAULT_NONE,
		FAULT_PUSH_OVF,
		FAULT_POP_UNF,
		FAULT_DIV_ZERO,
		FAULT_GLOBAL,
		FAULT_UNIMPL,
		FAULT_GUARD,
		FAULT_HALTED
	} fault_t;

	typedef enum logic [3:0] {
		CLS_CONST,
		CLS_CONSTINT,
		CLS_ACC,
		CLS_PUSH,
		CLS_POP,
		CLS_ASSIGN,
		CLS_ARITH,
		CLS_MDU,
		CLS_SHIFT,
		CLS_CMP,
		CLS_BRANCH,
		CLS_STOP,
		CLS_GETG,
		CLS_SETG,
		CLS_NOP,
		CLS_BAD
	} cls_t;

	typedef enum logic [1:0] {
		MDU_MUL,
		MDU_DIV,
		MDU_MOD
	} mdu_op_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_EXEC,
		B_MDU
	} back_state_t;

	// one classified instruction on its way from front to back
	typedef struct packed {
		logic [ACTION_BITS-1:0]  action;
		logic [OPERAND_BITS-1:0] operand;
		cls_t                    cls;
		logic                    pops;   // binary op: pops its stack operand
		logic [LEN_BITS-1:0]     len;    // pc advance when not branching
	} insn_t;

endpackage

// ===== rtl/core/zam_bytecode_execute_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zam_bytecode_execute_unit
// Tagged-word stack machine executing one decoded instruction per transaction.
// ---------------------------------------------------------------------------
// Each input transaction carries one instruction (tuser = dense operation code,
// tdata = raw operand) and yields exactly one output transaction with the
// accumulator, next pc, halt and yield flags and a fault code. A front stage
// classifies instructions into a two-entry queue; the execute stage runs them
// one at a time through take, stack/global RAM read and execute steps, the
// read step set by the registered read of the stack and globals memories.
// MUL, DIV and MOD then run through a bit-serial multiply/divide unit. A
// result register decouples the output, so a stalled sink holds back
// execution only once a finished result is waiting. Any fault halts the unit;
// every later instruction reports the "already halted" code. Write the yield
// period only while the unit is idle.
// ---------------------------------------------------------------------------
module zam_bytecode_execute_unit #(
	parameter int STACK_DEPTH  = zam_pkg::STACK_DEPTH_DEF,
	parameter int GLOBAL_SLOTS = zam_pkg::GLOBAL_SLOTS_DEF,
	parameter int WORD_BITS    = zam_pkg::WORD_BITS_DEF,
	parameter int PC_BITS      = zam_pkg::PC_BITS_DEF,
	localparam int OUT_BITS    = WORD_BITS + PC_BITS + 2 + zam_pkg::FAULT_BITS,
	localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// instruction stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [zam_pkg::OPERAND_BITS-1:0]  s_axis_tdata,  // operand
	input  logic [zam_pkg::ACTION_BITS-1:0]   s_axis_tuser,  // action
	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// accu_value, next_pc, halted_flag, yield_flag, fault_code, zero pad
	output logic [OUT_W-1:0]                  m_axis_tdata,
	// configuration
	input  logic                              cfg_wr_en,
	input  logic [zam_pkg::CFG_BITS-1:0]      cfg_wr_data    // yield period
);

	// yield period register; a value of 0 behaves as 1 through the reload
	logic [zam_pkg::CFG_BITS-1:0] yield_period_q;

	logic                   insn_valid, insn_ready;
	zam_pkg::insn_t         insn;
	logic [WORD_BITS-1:0]   accu_value;
	logic [PC_BITS-1:0]     next_pc;
	logic                   halted_flag, yield_flag;
	zam_pkg::fault_t        fault_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yield_period_q <= zam_pkg::YIELD_RESET;
		end else if (cfg_wr_en) begin
			yield_period_q <= cfg_wr_data;
		end
	end

	// front: accept and classify, queue for the execute stage
	zam_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(s_axis_tvalid),
		.item_ready(s_axis_tready),
		.action    (s_axis_tuser),
		.operand   (s_axis_tdata),
		.insn_valid(insn_valid),
		.insn_ready(insn_ready),
		.insn      (insn)
	);

	// back: execute, hold the result until the sink takes it
	zam_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.GLOBAL_SLOTS(GLOBAL_SLOTS),
		.WORD_BITS   (WORD_BITS),
		.PC_BITS     (PC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.yield_period(yield_period_q),
		.insn_valid  (insn_valid),
		.insn_ready  (insn_ready),
		.insn        (insn),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.accu_value  (accu_value),
		.next_pc     (next_pc),
		.halted_flag (halted_flag),
		.yield_flag  (yield_flag),
		.fault_code  (fault_code)
	);

	// pack result fields, first field in the low bits
	assign m_axis_tdata = OUT_W'({fault_code, yield_flag, halted_flag, next_pc, accu_value});

	// any reported fault leaves the unit halted
	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (fault_code != zam_pkg::FAULT_NONE) |-> halted_flag)
		else $error("fault reported without halt");

	// a yield only comes from a clean, non-halting completion
	a_yield_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && yield_flag |-> (fault_code == zam_pkg::FAULT_NONE) && !halted_flag)
		else $error("yield flag on a faulting or halting transaction");

endmodule

// ===== rtl/core/zam_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zam_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module zam_ram #(
	parameter int WIDTH = zam_pkg::WORD_BITS_DEF,
	parameter int DEPTH = zam_pkg::STACK_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/zam_mdu.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zam_mdu
// Iterative multiply / divide unit: one shift-add or one restoring step a cycle.
// ---------------------------------------------------------------------------
module zam_mdu #(
	parameter int WORD_BITS = zam_pkg::WORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  zam_pkg::mdu_op_t      op,
	input  logic [WORD_BITS-1:0]  a,
	input  logic [WORD_BITS-1:0]  b,
	output logic                  done,
	output logic [WORD_BITS-1:0]  result
);

	localparam int CW = $clog2(WORD_BITS + 1);

	logic                 busy_q, done_q;
	logic [CW-1:0]        cnt_q;
	zam_pkg::mdu_op_t     op_q;
	logic                 negq_q, negr_q;
	logic [WORD_BITS-1:0] x_q, y_q, p_q;
	logic [WORD_BITS-1:0] a_mag, b_mag;
	logic [WORD_BITS:0]   trial;

	assign a_mag = a[WORD_BITS-1] ? (~a + WORD_BITS'(1)) : a;
	assign b_mag = b[WORD_BITS-1] ? (~b + WORD_BITS'(1)) : b;
	assign trial = {p_q, x_q[WORD_BITS-1]} - {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(WORD_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= op;
			p_q    <= '0;
			negq_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
			negr_q <= a[WORD_BITS-1];
			if (op == zam_pkg::MDU_MUL) begin
				x_q <= a;
				y_q <= b;
			end else begin
				x_q <= a_mag;
				y_q <= b_mag;
			end
		end else if (busy_q) begin
			if (op_q == zam_pkg::MDU_MUL) begin
				if (y_q[0]) begin
					p_q <= p_q + x_q;
				end
				x_q <= x_q << 1;
				y_q <= y_q >> 1;
			end else if (!trial[WORD_BITS]) begin
				p_q <= trial[WORD_BITS-1:0];
				x_q <= {x_q[WORD_BITS-2:0], 1'b1};
			end else begin
				p_q <= {p_q[WORD_BITS-2:0], x_q[WORD_BITS-1]};
				x_q <= {x_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		unique case (op_q)
			zam_pkg::MDU_DIV: result = negq_q ? (~x_q + WORD_BITS'(1)) : x_q;
			zam_pkg::MDU_MOD: result = negr_q ? (~p_q + WORD_BITS'(1)) : p_q;
			default:          result = p_q;
		endcase
	end

	assign done = done_q;

endmodule

// ===== rtl/core/zam_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zam_front
// Accept instructions, classify them and hold them in a short queue.
// ---------------------------------------------------------------------------
module zam_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic [zam_pkg::ACTION_BITS-1:0]    action,
	input  logic [zam_pkg::OPERAND_BITS-1:0]   operand,
	output logic                               insn_valid,
	input  logic                               insn_ready,
	output zam_pkg::insn_t                     insn
);

	localparam int QAW = $clog2(zam_pkg::QUEUE_DEPTH);
	localparam int QCW = $clog2(zam_pkg::QUEUE_DEPTH + 1);

	zam_pkg::insn_t fifo_q [zam_pkg::QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] count_q;
	zam_pkg::insn_t dec;
	logic           push, pop;

	always_comb begin
		dec.action  = action;
		dec.operand = operand;
		dec.cls     = zam_pkg::CLS_BAD;
		dec.pops    = 1'b0;
		dec.len     = '0;
		priority if (action <= zam_pkg::OP_CONST3) begin
			dec.cls = zam_pkg::CLS_CONST;    dec.len = 3'd1;
		end else if (action == zam_pkg::OP_CONSTINT) begin
			dec.cls = zam_pkg::CLS_CONSTINT; dec.len = 3'd5;
		end else if (action <= zam_pkg::OP_ACC7) begin
			dec.cls = zam_pkg::CLS_ACC;      dec.len = 3'd1;
		end else if (action == zam_pkg::OP_ACC) begin
			dec.cls = zam_pkg::CLS_ACC;      dec.len = 3'd2;
		end else if (action <= zam_pkg::OP_PUSHACC3) begin
			dec.cls = zam_pkg::CLS_PUSH;     dec.len = 3'd1;
		end else if (action == zam_pkg::OP_PUSHACC) begin
			dec.cls = zam_pkg::CLS_PUSH;     dec.len = 3'd2;
		end else if (action == zam_pkg::OP_POP) begin
			dec.cls = zam_pkg::CLS_POP;      dec.len = 3'd3;
		end else if (action == zam_pkg::OP_ASSIGN) begin
			dec.cls = zam_pkg::CLS_ASSIGN;   dec.len = 3'd2;
		end else if (action <= zam_pkg::OP_SUB) begin
			dec.cls = zam_pkg::CLS_ARITH;    dec.len = 3'd1; dec.pops = 1'b1;
		end else if (action <= zam_pkg::OP_MOD) begin
			dec.cls = zam_pkg::CLS_MDU;      dec.len = 3'd1; dec.pops = 1'b1;
		end else if (action == zam_pkg::OP_NEG) begin
			dec.cls = zam_pkg::CLS_ARITH;    dec.len = 3'd1;
		end else if (action == zam_pkg::OP_OFFSETINT) begin
			dec.cls = zam_pkg::CLS_ARITH;    dec.len = 3'd2;
		end else if (action <= zam_pkg::OP_XOR) begin
			dec.cls = zam_pkg::CLS_ARITH;    dec.len = 3'd1; dec.pops = 1'b1;
		end else if (action <= zam_pkg::OP_ASR) begin
			dec.cls = zam_pkg::CLS_SHIFT;    dec.len = 3'd1; dec.pops = 1'b1;
		end else if (action <= zam_pkg::OP_GE) begin
			dec.cls = zam_pkg::CLS_CMP;      dec.len = 3'd1; dec.pops = 1'b1;
		end else if (action <= zam_pkg::OP_BRANCHIFNOT) begin
			dec.cls = zam_pkg::CLS_BRANCH;   dec.len = 3'd5;
		end else if (action == zam_pkg::OP_STOP) begin
			dec.cls = zam_pkg::CLS_STOP;     dec.len = 3'd1;
		end else if (action == zam_pkg::OP_GETGLOBAL) begin
			dec.cls = zam_pkg::CLS_GETG;     dec.len = 3'd5;
		end else if (action == zam_pkg::OP_SETGLOBAL) begin
			dec.cls = zam_pkg::CLS_SETG;     dec.len = 3'd5;
		end else if (action == zam_pkg::OP_ATOM0) begin
			dec.cls = zam_pkg::CLS_NOP;      dec.len = 3'd5;
		end else begin
			dec.cls = zam_pkg::CLS_BAD;
		end
	end

	assign item_ready = (count_q != QCW'(zam_pkg::QUEUE_DEPTH));
	assign insn_valid = (count_q != '0);
	assign push       = item_valid && item_ready;
	assign pop        = insn_valid && insn_ready;
	assign insn       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

endmodule

// ===== rtl/core/zam_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zam_back
// Execute classified instructions against accumulator, stack and globals.
// ---------------------------------------------------------------------------
module zam_back #(
	parameter int STACK_DEPTH  = zam_pkg::STACK_DEPTH_DEF,
	parameter int GLOBAL_SLOTS = zam_pkg::GLOBAL_SLOTS_DEF,
	parameter int WORD_BITS    = zam_pkg::WORD_BITS_DEF,
	parameter int PC_BITS      = zam_pkg::PC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [zam_pkg::CFG_BITS-1:0]    yield_period,
	input  logic                            insn_valid,
	output logic                            insn_ready,
	input  zam_pkg::insn_t                  insn,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic [WORD_BITS-1:0]            accu_value,
	output logic [PC_BITS-1:0]              next_pc,
	output logic                            halted_flag,
	output logic                            yield_flag,
	output zam_pkg::fault_t                 fault_code
);

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = SAW + 1;
	localparam int RIW = ((SPW > 8) ? SPW : 8) + 1;
	localparam int PW  = ((SPW > 16) ? SPW : 16) + 1;
	localparam int GAW = (GLOBAL_SLOTS > 1) ? $clog2(GLOBAL_SLOTS) : 1;
	localparam int HWW = $clog2(GLOBAL_SLOTS + 1);
	localparam int CB  = zam_pkg::CFG_BITS;
	localparam int OB  = zam_pkg::OPERAND_BITS;

	zam_pkg::back_state_t    state_q, state_d;
	zam_pkg::insn_t          cur_q;
	logic [WORD_BITS-1:0]    acc_q, acc_d;
	logic [SPW-1:0]          sp_q, sp_d;
	logic [PC_BITS-1:0]      pc_q, pc_d;
	logic                    halt_q, halt_d;
	logic [CB-1:0]           cnt_q, cnt_d;
	logic [HWW-1:0]          hw_q, hw_d;

	logic                    out_valid_q;
	logic [WORD_BITS-1:0]    out_acc_q;
	logic [PC_BITS-1:0]      out_pc_q;
	logic                    out_halt_q, out_yield_q;
	zam_pkg::fault_t         out_fault_q;

	logic                    out_free, fire, done_ok;
	zam_pkg::fault_t         o_fault;
	logic                    o_yield;

	// execution datapath
	logic [zam_pkg::ACTION_BITS-1:0] op;
	logic [OB-1:0]           arg;
	logic [PC_BITS-1:0]      pc1;
	logic signed [WORD_BITS-1:0] ua, ub;
	logic [WORD_BITS-1:0]    srd, grd, rd_val;
	logic [RIW-1:0]          rd_idx, as_idx;
	logic [SPW-1:0]          sp_m1;
	logic [PW-1:0]           room;
	logic [63:0]             s32x, s8x;
	logic [5:0]              shamt;
	logic                    taken;

	logic [WORD_BITS-1:0]    r_acc;
	logic [SPW-1:0]          r_sp;
	logic [PC_BITS-1:0]      r_pc;
	zam_pkg::fault_t         r_flt;
	logic                    r_sw, r_gw, r_stop, r_mdu;
	logic [SAW-1:0]          r_swa;
	logic [HWW-1:0]          r_hw;

	logic                    sw_en, gw_en, mdu_start, mdu_done;
	zam_pkg::mdu_op_t        mdu_op;
	logic [WORD_BITS-1:0]    mdu_res;

	assign op    = cur_q.action;
	assign arg   = cur_q.operand;
	assign pc1   = pc_q + PC_BITS'(1);
	assign ua    = {acc_q[WORD_BITS-1], acc_q[WORD_BITS-1:1]};
	assign ub    = {srd[WORD_BITS-1], srd[WORD_BITS-1:1]};
	assign sp_m1 = sp_q - SPW'(1);
	assign s32x  = {{32{arg[31]}}, arg};
	assign s8x   = {{56{arg[7]}}, arg[7:0]};
	assign shamt = ub[5:0];
	assign room  = PW'(STACK_DEPTH) - PW'(sp_q);
	assign as_idx = RIW'(sp_q) + RIW'(arg[7:0]);

	// stack read address for the instruction in hand; a push reads relative
	// to the stack pointer before the push
	always_comb begin
		unique case (cur_q.cls)
			zam_pkg::CLS_ACC: begin
				if (op == zam_pkg::OP_ACC) begin
					rd_idx = RIW'(sp_q) + RIW'(arg[7:0]);
				end else begin
					rd_idx = RIW'(sp_q) + RIW'(6'(op - zam_pkg::OP_ACC0));
				end
			end
			zam_pkg::CLS_PUSH: begin
				if (op == zam_pkg::OP_PUSHACC) begin
					rd_idx = RIW'(sp_q) + RIW'(arg[7:0]);
				end else begin
					rd_idx = RIW'(sp_q) + RIW'(6'(op - zam_pkg::OP_PUSHACC0));
				end
			end
			default: rd_idx = RIW'(sp_q);
		endcase
	end

	assign rd_val = (rd_idx >= RIW'(STACK_DEPTH)) ? '0 : srd;

	// instruction result before yield and guard
	always_comb begin
		r_acc  = acc_q;
		r_sp   = cur_q.pops ? (sp_q + SPW'(1)) : sp_q;
		r_pc   = pc_q + PC_BITS'(cur_q.len);
		r_flt  = zam_pkg::FAULT_NONE;
		r_sw   = 1'b0;
		r_swa  = sp_m1[SAW-1:0];
		r_gw   = 1'b0;
		r_hw   = hw_q;
		r_stop = 1'b0;
		r_mdu  = 1'b0;
		taken  = 1'b0;
		if (cur_q.pops && (sp_q >= SPW'(STACK_DEPTH))) begin
			r_flt = zam_pkg::FAULT_POP_UNF;
		end else begin
			unique case (cur_q.cls)
				zam_pkg::CLS_CONST: begin
					r_acc = {(WORD_BITS-1)'(op - zam_pkg::OP_CONST0), 1'b1};
				end
				zam_pkg::CLS_CONSTINT: r_acc = {s32x[WORD_BITS-2:0], 1'b1};
				zam_pkg::CLS_ACC:      r_acc = rd_val;
				zam_pkg::CLS_PUSH: begin
					if (sp_q == '0) begin
						r_flt = zam_pkg::FAULT_PUSH_OVF;
					end else begin
						r_sp = sp_m1;
						r_sw = 1'b1;
						if (op != zam_pkg::OP_PUSH) begin
							r_acc = rd_val;
						end
					end
				end
				zam_pkg::CLS_POP: begin
					if (PW'(arg[15:0]) > room) begin
						r_flt = zam_pkg::FAULT_POP_UNF;
					end else begin
						r_sp = SPW'(PW'(sp_q) + PW'(arg[15:0]));
					end
				end
				zam_pkg::CLS_ASSIGN: begin
					r_sw  = (as_idx < RIW'(STACK_DEPTH));
					r_swa = as_idx[SAW-1:0];
				end
				zam_pkg::CLS_ARITH: begin
					unique case (op)
						zam_pkg::OP_ADD:       r_acc = acc_q + srd - WORD_BITS'(1);
						zam_pkg::OP_SUB:       r_acc = acc_q - srd + WORD_BITS'(1);
						zam_pkg::OP_NEG:       r_acc = {(~ua[WORD_BITS-2:0]) +
							(WORD_BITS-1)'(1), 1'b1};
						zam_pkg::OP_OFFSETINT: r_acc = acc_q + {s8x[WORD_BITS-2:0], 1'b0};
						zam_pkg::OP_AND:       r_acc = {ua[WORD_BITS-2:0] & ub[WORD_BITS-2:0],
							1'b1};
						zam_pkg::OP_OR:        r_acc = {ua[WORD_BITS-2:0] | ub[WORD_BITS-2:0],
							1'b1};
						default:               r_acc = {ua[WORD_BITS-2:0] ^ ub[WORD_BITS-2:0],
							1'b1};
					endcase
				end
				zam_pkg::CLS_MDU: begin
					if (op != zam_pkg::OP_MUL && ub == '0) begin
						r_flt = zam_pkg::FAULT_DIV_ZERO;
					end else begin
						r_mdu = 1'b1;
					end
				end
				zam_pkg::CLS_SHIFT: begin
					unique case (op)
						zam_pkg::OP_LSL: begin
							r_acc = ua << shamt;
							r_acc = {r_acc[WORD_BITS-2:0], 1'b1};
						end
						zam_pkg::OP_LSR: r_acc = (acc_q >> shamt) | WORD_BITS'(1);
						default: begin
							r_acc = ua >>> shamt;
							r_acc = {r_acc[WORD_BITS-2:0], 1'b1};
						end
					endcase
				end
				zam_pkg::CLS_CMP: begin
					unique case (op)
						zam_pkg::OP_EQ:  taken = (ub == ua);
						zam_pkg::OP_NEQ: taken = (ub != ua);
						zam_pkg::OP_LT:  taken = (ub < ua);
						zam_pkg::OP_LE:  taken = (ub <= ua);
						zam_pkg::OP_GT:  taken = (ub > ua);
						default:         taken = (ub >= ua);
					endcase
					r_acc = taken ? WORD_BITS'(3) : WORD_BITS'(1);
				end
				zam_pkg::CLS_BRANCH: begin
					unique case (op)
						zam_pkg::OP_BRANCH:   taken = 1'b1;
						zam_pkg::OP_BRANCHIF: taken = (ua != '0);
						default:              taken = (ua == '0);
					endcase
					if (taken) begin
						r_pc = pc1 + arg[PC_BITS-1:0];
					end
				end
				zam_pkg::CLS_STOP: r_stop = 1'b1;
				zam_pkg::CLS_GETG: begin
					if (arg >= OB'(hw_q) || arg >= OB'(GLOBAL_SLOTS)) begin
						r_flt = zam_pkg::FAULT_GLOBAL;
					end else begin
						r_acc = grd;
					end
				end
				zam_pkg::CLS_SETG: begin
					if (arg >= OB'(GLOBAL_SLOTS)) begin
						r_flt = zam_pkg::FAULT_GLOBAL;
					end else begin
						r_gw = 1'b1;
						if (arg >= OB'(hw_q)) begin
							r_hw = arg[HWW-1:0] + HWW'(1);
						end
					end
				end
				zam_pkg::CLS_NOP: r_acc = acc_q;
				default:          r_flt = zam_pkg::FAULT_UNIMPL;
			endcase
		end
	end

	always_comb begin
		priority if (op == zam_pkg::OP_MUL) begin
			mdu_op = zam_pkg::MDU_MUL;
		end else if (op == zam_pkg::OP_DIV) begin
			mdu_op = zam_pkg::MDU_DIV;
		end else begin
			mdu_op = zam_pkg::MDU_MOD;
		end
	end

	assign out_free   = !out_valid_q || res_ready;
	assign insn_ready = (state_q == zam_pkg::B_IDLE);

	// sequencer: next state and architectural update
	always_comb begin
		state_d   = state_q;
		acc_d     = acc_q;
		sp_d      = sp_q;
		pc_d      = pc_q;
		halt_d    = halt_q;
		cnt_d     = cnt_q;
		hw_d      = hw_q;
		fire      = 1'b0;
		done_ok   = 1'b0;
		sw_en     = 1'b0;
		gw_en     = 1'b0;
		mdu_start = 1'b0;
		o_fault   = zam_pkg::FAULT_NONE;
		o_yield   = 1'b0;
		unique case (state_q)
			zam_pkg::B_IDLE: begin
				if (insn_valid) begin
					state_d = zam_pkg::B_READ;
				end
			end
			zam_pkg::B_READ: state_d = zam_pkg::B_EXEC;
			zam_pkg::B_EXEC: begin
				if (out_free) begin
					if (halt_q) begin
						fire    = 1'b1;
						o_fault = zam_pkg::FAULT_HALTED;
						state_d = zam_pkg::B_IDLE;
					end else if (r_flt != zam_pkg::FAULT_NONE) begin
						fire    = 1'b1;
						halt_d  = 1'b1;
						o_fault = r_flt;
						state_d = zam_pkg::B_IDLE;
					end else if (r_mdu) begin
						mdu_start = 1'b1;
						state_d   = zam_pkg::B_MDU;
					end else begin
						fire    = 1'b1;
						done_ok = 1'b1;
						acc_d   = r_acc;
						sp_d    = r_sp;
						pc_d    = r_pc;
						hw_d    = r_hw;
						sw_en   = r_sw;
						gw_en   = r_gw;
						state_d = zam_pkg::B_IDLE;
					end
				end
			end
			zam_pkg::B_MDU: begin
				if (mdu_done && out_free) begin
					fire    = 1'b1;
					done_ok = 1'b1;
					acc_d   = {mdu_res[WORD_BITS-2:0], 1'b1};
					sp_d    = sp_q + SPW'(1);
					pc_d    = pc1;
					state_d = zam_pkg::B_IDLE;
				end
			end
			default: state_d = zam_pkg::B_IDLE;
		endcase
		if (done_ok) begin
			if (r_stop) begin
				halt_d = 1'b1;
			end else if (cnt_q <= CB'(1)) begin
				cnt_d   = yield_period;
				o_yield = 1'b1;
			end else begin
				cnt_d = cnt_q - CB'(1);
				if (sp_d <= SPW'(zam_pkg::GUARD_SLOTS)) begin
					halt_d  = 1'b1;
					o_fault = zam_pkg::FAULT_GUARD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= zam_pkg::B_IDLE;
			acc_q       <= WORD_BITS'(1);
			sp_q        <= SPW'(STACK_DEPTH);
			pc_q        <= '0;
			halt_q      <= 1'b0;
			cnt_q       <= zam_pkg::YIELD_RESET;
			hw_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			sp_q    <= sp_d;
			pc_q    <= pc_d;
			halt_q  <= halt_d;
			cnt_q   <= cnt_d;
			hw_q    <= hw_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == zam_pkg::B_IDLE && insn_valid) begin
			cur_q <= insn;
		end
		if (fire) begin
			out_acc_q   <= acc_d;
			out_pc_q    <= pc_d;
			out_halt_q  <= halt_d;
			out_yield_q <= o_yield;
			out_fault_q <= o_fault;
		end
	end

	zam_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (sw_en),
		.wr_addr(r_swa),
		.wr_data(acc_q),
		.rd_addr(rd_idx[SAW-1:0]),
		.rd_data(srd)
	);

	zam_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(GLOBAL_SLOTS)
	) u_globals (
		.clk    (clk),
		.wr_en  (gw_en),
		.wr_addr(arg[GAW-1:0]),
		.wr_data(acc_q),
		.rd_addr(arg[GAW-1:0]),
		.rd_data(grd)
	);

	zam_mdu #(
		.WORD_BITS(WORD_BITS)
	) u_mdu (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mdu_start),
		.op    (mdu_op),
		.a     (ua),
		.b     (ub),
		.done  (mdu_done),
		.result(mdu_res)
	);

	assign res_valid   = out_valid_q;
	assign accu_value  = out_acc_q;
	assign next_pc     = out_pc_q;
	assign halted_flag = out_halt_q;
	assign yield_flag  = out_yield_q;
	assign fault_code  = out_fault_q;

endmodule
